FILE: hw/rtl/ptca_pkg.sv
// shared types, constants and helpers for the pwm timer and channel allocator
// used by ptca_ctrl, ptca_dpath and pwm_timer_channel_allocator
`timescale 1ns / 1ps

package ptca_pkg;

	localparam int unsigned NUM_TIMERS   = 4;
	localparam int unsigned NUM_CHANNELS = 8;

	localparam int unsigned TMR_W  = $clog2(NUM_TIMERS);
	localparam int unsigned CH_W   = $clog2(NUM_CHANNELS);
	localparam int unsigned FREQ_W = 27;
	localparam int unsigned DUTY_W = 16;
	localparam int unsigned RES_W  = 4;
	localparam int unsigned SD_W   = 13;
	localparam int unsigned OP_W   = 2;
	localparam int unsigned STAT_W = 3;

	localparam logic [RES_W-1:0]  RES_CAP       = RES_W'(13);
	localparam logic [FREQ_W-1:0] BASE_CLK_RST  = FREQ_W'(80000000);
	// freq shifted left by up to RES_CAP + 1
	localparam int unsigned       SH_W          = FREQ_W + 14;

	localparam int unsigned IN_TDATA_W  = 48;
	localparam int unsigned OUT_TDATA_W = 32;

	typedef enum logic [OP_W-1:0] {
		OP_ACQUIRE  = 2'd0,
		OP_RELEASE  = 2'd1,
		OP_SET_DUTY = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_BAD_FREQ  = 3'd1,
		ST_NO_TIMER  = 3'd2,
		ST_NO_CHAN   = 3'd3,
		ST_NOT_ALLOC = 3'd4
	} status_t;

	// packed from the top bit down, so status lands in the lowest bits
	typedef struct packed {
		logic              timer_freed;
		logic [SD_W-1:0]   scaled_duty;
		logic [RES_W-1:0]  resolution_bits;
		logic [CH_W-1:0]   chan_idx;
		logic [TMR_W-1:0]  tmr_idx;
		status_t           status;
	} result_t;

	localparam int unsigned RESULT_W = $bits(result_t);

	typedef struct packed {
		logic    load;
		logic    res_start;
		logic    res_step;
		logic    tscan_start;
		logic    tscan_step;
		logic    acq_commit;
		logic    rel_commit;
		logic    duty_result;
		logic    emit;
		status_t emit_status;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic freq_bad;
		logic ch_in_use;
		logic res_more;
		logic res_zero;
		logic timer_hit;
		logic timer_last;
		logic chan_free;
		logic out_busy;
	} sts_t;

	function automatic logic [SD_W-1:0] scale_duty(input logic [DUTY_W-1:0] duty,
	                                               input logic [RES_W-1:0] res);
		logic [DUTY_W-1:0] sh;
		logic [4:0]        amt;
		amt = 5'd16 - {1'b0, res};
		sh  = duty >> amt;
		return sh[SD_W-1:0];
	endfunction

endpackage

FILE: hw/rtl/pwm_timer_channel_allocator.sv
// top level of the pwm timer and channel allocator
// depends on ptca_pkg, ptca_ctrl and ptca_dpath
`timescale 1ns / 1ps

// Hands out PWM timers and channels one request at a time. For an acquire,
// the duty resolution is found by a shift-and-compare unit at one bit per
// cycle, then the timers are scanned one per cycle (up to 4), then the first
// free channel is taken. Release and set duty skip the search, and an item
// with op 3 is dropped with no result. A new item is taken once the previous
// one has reached the output register, so one result may wait on the master
// side while the next item is worked on.
module pwm_timer_channel_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [ptca_pkg::FREQ_W-1:0]      cfg_wr_data,     // base_clock_hz
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// frequency[26:0], var_freq[27], duty[43:28], channel[46:44]
	input  logic [ptca_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic [ptca_pkg::OP_W-1:0]        s_axis_tuser,    // op[1:0]
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// status[2:0], tmr_idx[4:3], chan_idx[7:5], resolution_bits[11:8],
	// scaled_duty[24:12], timer_freed[25]
	output logic [ptca_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import ptca_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ptca_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	ptca_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cmd           (cmd),
		.sts           (sts),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

FILE: hw/rtl/ptca_ctrl.sv
// sequencing state machine for the allocator
// depends on ptca_pkg; drives commands into ptca_dpath and reads its status
`timescale 1ns / 1ps

module ptca_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  ptca_pkg::sts_t sts,
	output ptca_pkg::cmd_t cmd
);
	import ptca_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_RES    = 6'b000100,
		S_TSCAN  = 6'b001000,
		S_CHAN   = 6'b010000,
		S_EMIT   = 6'b100000
	} state_t;

	state_t  state_q, state_d;
	status_t status_q, status_d;

	assign s_axis_tready = (state_q == S_IDLE);

	always_comb begin
		state_d         = state_q;
		status_d        = status_q;
		cmd             = '0;
		cmd.emit_status = status_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.op) inside
					OP_ACQUIRE: begin
						if (sts.freq_bad) begin
							status_d = ST_BAD_FREQ;
							state_d  = S_EMIT;
						end else begin
							cmd.res_start = 1'b1;
							state_d       = S_RES;
						end
					end
					OP_RELEASE, OP_SET_DUTY: begin
						state_d = S_EMIT;
						if (!sts.ch_in_use) begin
							status_d = ST_NOT_ALLOC;
						end else begin
							status_d = ST_OK;
							if (sts.op == OP_RELEASE) begin
								cmd.rel_commit = 1'b1;
							end else begin
								cmd.duty_result = 1'b1;
							end
						end
					end
					default: begin
						// unused opcode: dropped without a result
						state_d = S_IDLE;
					end
				endcase
			end
			S_RES: begin
				if (sts.res_more) begin
					cmd.res_step = 1'b1;
				end else if (sts.res_zero) begin
					status_d = ST_BAD_FREQ;
					state_d  = S_EMIT;
				end else begin
					cmd.tscan_start = 1'b1;
					state_d         = S_TSCAN;
				end
			end
			S_TSCAN: begin
				if (sts.timer_hit) begin
					state_d = S_CHAN;
				end else if (sts.timer_last) begin
					status_d = ST_NO_TIMER;
					state_d  = S_EMIT;
				end else begin
					cmd.tscan_step = 1'b1;
				end
			end
			S_CHAN: begin
				state_d = S_EMIT;
				if (sts.chan_free) begin
					cmd.acq_commit = 1'b1;
					status_d       = ST_OK;
				end else begin
					status_d = ST_NO_CHAN;
				end
			end
			S_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

endmodule

FILE: hw/rtl/ptca_dpath.sv
// datapath: input capture, resolution search, timer and channel tables,
// result and output registers; depends on ptca_pkg, commanded by ptca_ctrl
`timescale 1ns / 1ps

module ptca_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [ptca_pkg::FREQ_W-1:0]        cfg_wr_data,
	input  logic [ptca_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	input  logic [ptca_pkg::OP_W-1:0]          s_axis_tuser,
	input  ptca_pkg::cmd_t                     cmd,
	output ptca_pkg::sts_t                     sts,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [ptca_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import ptca_pkg::*;

	logic [FREQ_W-1:0] base_q;

	op_t               op_q;
	logic [FREQ_W-1:0] freq_q;
	logic              vf_q;
	logic [DUTY_W-1:0] duty_q;
	logic [CH_W-1:0]   ch_q;

	logic [FREQ_W-1:0]       tf_q [NUM_TIMERS];
	logic [NUM_TIMERS-1:0]   excl_q;
	logic [NUM_CHANNELS-1:0] in_use_q;
	logic [TMR_W-1:0]        ctim_q [NUM_CHANNELS];
	logic [RES_W-1:0]        cres_q [NUM_CHANNELS];

	logic [SH_W-1:0]  sh_q;
	logic [RES_W-1:0] res_q;
	logic [TMR_W-1:0] t_q;

	result_t                rslt_q;
	result_t                out_d;
	logic                   out_valid_q;
	logic [RESULT_W-1:0]    out_data_q;

	logic             free_any;
	logic [CH_W-1:0]  free_idx;
	logic             taken;
	logic             freed;
	logic [TMR_W-1:0] rel_tim;
	logic [RES_W-1:0] rel_res;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_CLK_RST;
		end else if (cfg_wr_en) begin
			base_q <= cfg_wr_data;
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(s_axis_tuser);
			freq_q <= s_axis_tdata[26:0];
			vf_q   <= s_axis_tdata[27];
			duty_q <= s_axis_tdata[43:28];
			ch_q   <= s_axis_tdata[46:44];
		end
	end

	assign rel_tim = ctim_q[ch_q];
	assign rel_res = cres_q[ch_q];

	// first free channel
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
			if (!in_use_q[c]) begin
				free_any = 1'b1;
				free_idx = CH_W'(c);
			end
		end
	end

	// another channel still on the releasing channel's timer
	always_comb begin
		taken = 1'b0;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			if (in_use_q[c] && (CH_W'(c) != ch_q) && (ctim_q[c] == rel_tim)) begin
				taken = 1'b1;
			end
		end
	end

	assign freed = !taken || excl_q[rel_tim];

	// resolution search: freq << (r + 1) <= base means floor(base / freq) >= 2^(r + 1)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
			sh_q  <= '0;
			t_q   <= '0;
		end else begin
			if (cmd.res_start) begin
				res_q <= '0;
				sh_q  <= {{(SH_W - FREQ_W){1'b0}}, freq_q} << 1;
			end else if (cmd.res_step) begin
				res_q <= res_q + RES_W'(1);
				sh_q  <= sh_q << 1;
			end
			if (cmd.tscan_start) begin
				t_q <= '0;
			end else if (cmd.tscan_step) begin
				t_q <= t_q + TMR_W'(1);
			end
		end
	end

	// timer and channel ownership tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NUM_TIMERS; t++) begin
				tf_q[t] <= '0;
			end
			excl_q   <= '0;
			in_use_q <= '0;
		end else if (cmd.acq_commit) begin
			tf_q[t_q]          <= freq_q;
			excl_q[t_q]        <= excl_q[t_q] | vf_q;
			in_use_q[free_idx] <= 1'b1;
		end else if (cmd.rel_commit) begin
			in_use_q[ch_q] <= 1'b0;
			if (freed) begin
				tf_q[rel_tim]   <= '0;
				excl_q[rel_tim] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acq_commit) begin
			ctim_q[free_idx] <= t_q;
			cres_q[free_idx] <= res_q;
		end
	end

	// staged result for the ok case
	always_ff @(posedge clk) begin
		if (cmd.acq_commit) begin
			rslt_q.status          <= ST_OK;
			rslt_q.tmr_idx         <= t_q;
			rslt_q.chan_idx        <= free_idx;
			rslt_q.resolution_bits <= res_q;
			rslt_q.scaled_duty     <= scale_duty(duty_q, res_q);
			rslt_q.timer_freed     <= 1'b0;
		end else if (cmd.rel_commit) begin
			rslt_q.status          <= ST_OK;
			rslt_q.tmr_idx         <= rel_tim;
			rslt_q.chan_idx        <= ch_q;
			rslt_q.resolution_bits <= rel_res;
			rslt_q.scaled_duty     <= '0;
			rslt_q.timer_freed     <= freed;
		end else if (cmd.duty_result) begin
			rslt_q.status          <= ST_OK;
			rslt_q.tmr_idx         <= rel_tim;
			rslt_q.chan_idx        <= ch_q;
			rslt_q.resolution_bits <= rel_res;
			rslt_q.scaled_duty     <= scale_duty(duty_q, rel_res);
			rslt_q.timer_freed     <= 1'b0;
		end
	end

	always_comb begin
		out_d        = '0;
		out_d.status = cmd.emit_status;
		if (cmd.emit_status == ST_OK) begin
			out_d = rslt_q;
		end else if (cmd.emit_status == ST_NOT_ALLOC) begin
			out_d.chan_idx = ch_q;
		end
	end

	// output register, frees the controller while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= out_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, out_data_q};

	assign sts.op         = op_q;
	assign sts.freq_bad   = (freq_q == '0) || (freq_q > base_q);
	assign sts.ch_in_use  = in_use_q[ch_q];
	assign sts.res_more   = (sh_q <= {{(SH_W - FREQ_W){1'b0}}, base_q}) && (res_q != RES_CAP);
	assign sts.res_zero   = (res_q == '0);
	assign sts.timer_hit  = ((tf_q[t_q] == freq_q) && !vf_q && !excl_q[t_q]) ||
	                        (tf_q[t_q] == '0);
	assign sts.timer_last = (t_q == TMR_W'(NUM_TIMERS - 1));
	assign sts.chan_free  = free_any;
	assign sts.out_busy   = out_valid_q && !m_axis_tready;

	a_acq_marks_channel: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acq_commit |=> in_use_q[$past(free_idx)])
		else $error("acquired channel not marked in use");

	a_rel_clears_channel: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rel_commit |=> !in_use_q[$past(ch_q)])
		else $error("released channel still in use");

	a_res_capped: assert property (@(posedge clk) disable iff (!arst_n)
		res_q <= RES_CAP)
		else $error("resolution above cap");

	a_excl_running: assert property (@(posedge clk) disable iff (!arst_n)
		excl_q[t_q] |-> (tf_q[t_q] != '0))
		else $error("exclusive timer marked free");

	a_emit_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid_q && !m_axis_tready))
		else $error("result overwrites a waiting item");

endmodule

FILE: dv/tb_pwm_timer_channel_allocator.sv
// self-checking testbench for pwm_timer_channel_allocator: directed table, then random phases
// depends on ptca_pkg and the allocator rtl only
`timescale 1ns / 1ps

module tb_pwm_timer_channel_allocator;

	import ptca_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int unsigned     DRAIN_CYCLES = 30;
	localparam int unsigned     LONG_HOLD = 300;
	localparam int unsigned     ITEMS_PER_PHASE = 100;
	localparam int unsigned     NUM_PHASES = 5;

	// packed so that frequency sits in the lowest bits of tdata
	typedef struct packed {
		logic [CH_W-1:0]   channel;
		logic [DUTY_W-1:0] duty;
		logic              vf;
		logic [FREQ_W-1:0] frequency;
	} alloc_req_t;

	typedef struct {
		logic [OP_W-1:0] op;
		alloc_req_t      req;
		bit              typed;
		result_t         want;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [FREQ_W-1:0]      cfg_wr_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;     // frequency, var_freq, duty, channel
	logic [OP_W-1:0]        s_axis_tuser;     // op
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;     // status, tmr_idx, chan_idx,
	                                          // resolution_bits, scaled_duty, timer_freed

	// allocator state as the predictor sees it
	logic [FREQ_W-1:0]  base_clk;
	logic [FREQ_W-1:0]  tmr_freq [NUM_TIMERS];
	logic               tmr_excl [NUM_TIMERS];
	logic               ch_busy  [NUM_CHANNELS];
	logic [TMR_W-1:0]   ch_tmr   [NUM_CHANNELS];
	logic [RES_W-1:0]   ch_res   [NUM_CHANNELS];
	logic [FREQ_W-1:0]  freq_pool [4];

	result_t  pending_results [$];
	dir_row_t dir_rows [$];

	int  mismatches;
	int  results_seen;
	int  items_sent;
	int  acq_granted;
	int  timers_freed;
	bit  no_idle;

	pwm_timer_channel_allocator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	// returns 1 when the item produces a result, and updates the allocator state
	function automatic bit predict_alloc(input logic [OP_W-1:0] op, input alloc_req_t rq,
	                                     output result_t rs);
		int unsigned ivl;
		int unsigned rbits;
		int          tim;
		int          chn;
		bit          shared;
		rs = '0;
		if (op == OP_UNUSED)
			return 1'b0;
		if (op == OP_ACQUIRE) begin
			if (rq.frequency == 0 || rq.frequency > base_clk) begin
				rs.status = ST_BAD_FREQ;
				return 1'b1;
			end
			ivl = base_clk / rq.frequency;
			rbits = 0;
			while (rbits < 31 && (ivl >> (rbits + 1)) != 0)
				rbits++;
			if (rbits > 13)
				rbits = 13;
			if (rbits == 0) begin
				rs.status = ST_BAD_FREQ;
				return 1'b1;
			end
			tim = -1;
			for (int t = 0; t < NUM_TIMERS; t++) begin
				if ((tmr_freq[t] == rq.frequency && !rq.vf && !tmr_excl[t]) ||
				    tmr_freq[t] == 0) begin
					tim = t;
					break;
				end
			end
			if (tim < 0) begin
				rs.status = ST_NO_TIMER;
				return 1'b1;
			end
			chn = -1;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				if (!ch_busy[c]) begin
					chn = c;
					break;
				end
			end
			if (chn < 0) begin
				rs.status = ST_NO_CHAN;
				return 1'b1;
			end
			tmr_freq[tim] = rq.frequency;
			if (rq.vf)
				tmr_excl[tim] = 1'b1;
			ch_busy[chn] = 1'b1;
			ch_tmr[chn] = TMR_W'(tim);
			ch_res[chn] = RES_W'(rbits);
			rs.status = ST_OK;
			rs.tmr_idx = TMR_W'(tim);
			rs.chan_idx = CH_W'(chn);
			rs.resolution_bits = RES_W'(rbits);
			rs.scaled_duty = SD_W'(rq.duty >> (16 - rbits));
			return 1'b1;
		end
		rs.chan_idx = rq.channel;
		if (!ch_busy[rq.channel]) begin
			rs.status = ST_NOT_ALLOC;
			return 1'b1;
		end
		rs.status = ST_OK;
		rs.tmr_idx = ch_tmr[rq.channel];
		rs.resolution_bits = ch_res[rq.channel];
		if (op == OP_SET_DUTY) begin
			rs.scaled_duty = SD_W'(rq.duty >> (16 - ch_res[rq.channel]));
			return 1'b1;
		end
		ch_busy[rq.channel] = 1'b0;
		shared = 1'b0;
		for (int c = 0; c < NUM_CHANNELS; c++)
			if (ch_busy[c] && ch_tmr[c] == ch_tmr[rq.channel])
				shared = 1'b1;
		// an exclusive timer goes back to the pool even if it looks shared
		if (!shared || tmr_excl[ch_tmr[rq.channel]]) begin
			tmr_freq[ch_tmr[rq.channel]] = '0;
			tmr_excl[ch_tmr[rq.channel]] = 1'b0;
			rs.timer_freed = 1'b1;
		end
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [FREQ_W-1:0] pick_freq();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return freq_pool[$urandom_range(0, 3)];
		if (r < 70)
			return base_clk >> $urandom_range(1, 26);
		if (r < 82)
			return FREQ_W'($urandom());
		if (r < 86)
			return '0;
		if (r < 92)
			return base_clk + FREQ_W'($urandom_range(1, 1000));
		// ratio below two gives zero resolution bits
		return base_clk - FREQ_W'($urandom_range(0, base_clk / 2));
	endfunction

	function automatic void add_row(input logic [OP_W-1:0] op, input logic [FREQ_W-1:0] freq,
	                                input logic vf, input logic [DUTY_W-1:0] duty,
	                                input logic [CH_W-1:0] chn, input bit typed = 1'b0,
	                                input status_t st = ST_OK, input int tmr = 0,
	                                input int och = 0, input int rbits = 0, input int sd = 0,
	                                input bit freed = 1'b0);
		dir_row_t row;
		row.op = op;
		row.req.frequency = freq;
		row.req.vf = vf;
		row.req.duty = duty;
		row.req.channel = chn;
		row.typed = typed;
		row.want = '0;
		row.want.status = st;
		row.want.tmr_idx = TMR_W'(tmr);
		row.want.chan_idx = CH_W'(och);
		row.want.resolution_bits = RES_W'(rbits);
		row.want.scaled_duty = SD_W'(sd);
		row.want.timer_freed = freed;
		dir_rows.push_back(row);
	endfunction

	task automatic send_item(input logic [OP_W-1:0] op, input alloc_req_t rq,
	                         input bit typed, input result_t want);
		result_t predicted;
		bit      has_result;
		int      gap;
		gap = no_idle ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, rq};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		has_result = predict_alloc(op, rq, predicted);
		if (has_result) begin
			pending_results.push_back(typed ? want : predicted);
			if (op == OP_ACQUIRE && predicted.status == ST_OK)
				acq_granted++;
			if (predicted.timer_freed)
				timers_freed++;
		end
	endtask

	// stop offering, let every result arrive, then allow for a dropped item still in flight
	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_base_clock(input logic [FREQ_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		base_clk = value;
		for (int i = 0; i < 4; i++) begin
			freq_pool[i] = value >> $urandom_range(1, 24);
			if (freq_pool[i] == 0)
				freq_pool[i] = 1;
		end
	endtask

	// receiver: random stalls plus one long hold-off to back the block up
	initial begin : receiver
		int  stall_left;
		bit  long_hold_done;
		int  g;
		stall_left = 0;
		long_hold_done = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!long_hold_done && results_seen >= 150) begin
				long_hold_done = 1'b1;
				stall_left = LONG_HOLD - 1;
				m_axis_tready <= 1'b0;
			end else if (no_idle) begin
				m_axis_tready <= 1'b1;
			end else begin
				g = pick_gap();
				if (g > 0) begin
					stall_left = g - 1;
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = result_t'(m_axis_tdata[RESULT_W-1:0]);
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: st=%0d tmr=%0d ch=%0d res=%0d duty=%0d freed=%0d",
					         got.status, got.tmr_idx, got.chan_idx,
					         got.resolution_bits, got.scaled_duty, got.timer_freed);
			end else begin
				want = pending_results.pop_front();
				if (got.status != want.status || got.tmr_idx != want.tmr_idx ||
				    got.chan_idx != want.chan_idx ||
				    got.resolution_bits != want.resolution_bits ||
				    got.scaled_duty != want.scaled_duty || got.timer_freed != want.timer_freed) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d mismatch: exp st=%0d tmr=%0d ch=%0d res=%0d",
						         results_seen, want.status, want.tmr_idx, want.chan_idx,
						         want.resolution_bits,
						         " duty=%0d freed=%0d, got st=%0d tmr=%0d ch=%0d",
						         want.scaled_duty, want.timer_freed,
						         got.status, got.tmr_idx, got.chan_idx,
						         " res=%0d duty=%0d freed=%0d",
						         got.resolution_bits, got.scaled_duty, got.timer_freed);
				end
			end
		end
	end

	initial begin : main
		logic [FREQ_W-1:0] phase_base;
		logic [OP_W-1:0]   op;
		alloc_req_t        rq;
		int                busy_ch [$];
		int                p_acq;
		int unsigned       r;
		int                n;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		no_idle = 1'b0;
		mismatches = 0;
		results_seen = 0;
		items_sent = 0;
		acq_granted = 0;
		timers_freed = 0;
		base_clk = BASE_CLK_RST;
		for (int t = 0; t < NUM_TIMERS; t++) begin
			tmr_freq[t] = '0;
			tmr_excl[t] = 1'b0;
		end
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			ch_busy[c] = 1'b0;
			ch_tmr[c] = '0;
			ch_res[c] = '0;
		end

		// directed rows assume the reset clock of 80 MHz
		add_row(OP_RELEASE, 0, 0, 0, 0, 1, ST_NOT_ALLOC, 0, 0);
		add_row(OP_SET_DUTY, 0, 0, 16'hFFFF, 7, 1, ST_NOT_ALLOC, 0, 7);
		add_row(OP_ACQUIRE, 0, 0, 16'hFFFF, 0, 1, ST_BAD_FREQ);
		add_row(OP_ACQUIRE, 27'h7FFFFFF, 1, 16'hFFFF, 7, 1, ST_BAD_FREQ);
		add_row(OP_ACQUIRE, 80000000, 0, 16'hFFFF, 0, 1, ST_BAD_FREQ);
		add_row(OP_ACQUIRE, 40000000, 0, 16'hFFFF, 0, 1, ST_OK, 0, 0, 1, 1);
		add_row(OP_ACQUIRE, 1, 0, 16'hFFFF, 0, 1, ST_OK, 1, 1, 13, 13'h1FFF);
		add_row(OP_ACQUIRE, 1, 0, 16'h8000, 0);
		add_row(OP_ACQUIRE, 1, 1, 16'h1234, 0);
		add_row(OP_ACQUIRE, 1000, 0, 16'h0000, 0);
		add_row(OP_ACQUIRE, 5000, 0, 16'hFFFF, 0, 1, ST_NO_TIMER);
		add_row(OP_ACQUIRE, 1, 0, 16'hABCD, 0);
		add_row(OP_ACQUIRE, 1, 0, 16'h5555, 0);
		add_row(OP_ACQUIRE, 1, 0, 16'hAAAA, 0);
		add_row(OP_ACQUIRE, 1, 0, 16'hFFFF, 0, 1, ST_NO_CHAN);
		add_row(OP_SET_DUTY, 0, 0, 16'hFFFF, 1);
		add_row(OP_SET_DUTY, 0, 0, 16'h0000, 0);
		add_row(OP_UNUSED, 27'h7FFFFFF, 1, 16'hFFFF, 7);
		add_row(OP_RELEASE, 0, 0, 0, 1);
		add_row(OP_RELEASE, 0, 0, 0, 3);
		add_row(OP_RELEASE, 0, 0, 0, 0);
		add_row(OP_ACQUIRE, 1, 1, 16'h7FFF, 0);
		add_row(OP_RELEASE, 0, 0, 0, 2);
		add_row(OP_SET_DUTY, 0, 0, 16'h1234, 2, 1, ST_NOT_ALLOC, 0, 2);
		add_row(OP_SET_DUTY, 0, 0, 16'h1234, 7);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_item(dir_rows[i].op, dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: phase_base = 1000000;
				1: phase_base = 27'h7FFFFFF;
				4: phase_base = 80000000;
				default: phase_base = FREQ_W'($urandom_range(1000000, 134217727));
			endcase
			drain_results();
			write_base_clock(phase_base);
			no_idle = (ph == 2);
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				busy_ch.delete();
				for (int c = 0; c < NUM_CHANNELS; c++)
					if (ch_busy[c])
						busy_ch.push_back(c);
				// fewer acquires as the pool fills so that releases keep it churning
				p_acq = 70 - 7 * busy_ch.size();
				r = $urandom_range(0, 99);
				if (r < 4)
					op = OP_UNUSED;
				else if (r < 4 + p_acq)
					op = OP_ACQUIRE;
				else if ($urandom_range(0, 9) < 6)
					op = OP_RELEASE;
				else
					op = OP_SET_DUTY;
				rq.frequency = pick_freq();
				rq.vf = ($urandom_range(0, 3) == 0);
				rq.duty = DUTY_W'($urandom());
				if (busy_ch.size() > 0 && $urandom_range(0, 99) < 85)
					rq.channel = CH_W'(busy_ch[$urandom_range(0, busy_ch.size() - 1)]);
				else
					rq.channel = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
				send_item(op, rq, 1'b0, '0);
				if (op != OP_UNUSED)
					n++;
			end
		end

		drain_results();
		if (pending_results.size() != 0)
			mismatches++;
		$display("covered %0d items and %0d results over %0d clock settings",
		         items_sent, results_seen, NUM_PHASES + 1);
		$display("%0d acquires granted, %0d timers returned to the pool", acq_granted, timers_freed);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
